// File: rtl/lkrc_pkg.sv
// Shared types, codes and time helpers for the link keepalive reconnect controller.
// No dependencies; every rtl file imports it.
package lkrc_pkg;

    localparam int TIME_BITS  = 48;
    localparam int CFG_BITS   = 31;
    localparam int ATT_BITS   = 16;
    localparam int KIND_BITS  = 3;
    localparam int STAT_BITS  = 3;
    localparam int MODE_BITS  = 2;
    localparam int IDX_BITS   = 3;

    // event kinds
    localparam logic [KIND_BITS-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_CONNECT = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_LOGIN   = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_FRAME   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_SEND    = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_LOST    = 3'd5;

    // link modes
    localparam logic [MODE_BITS-1:0] MODE_DOWN  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOGIN = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_READY = 2'd2;

    // status codes
    localparam logic [STAT_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_IO      = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_NOLOGIN = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_DUP     = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_QFULL   = 3'd4;

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_HB_INTERVAL = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_IDLE_TO     = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_LOGIN_TO    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_BACKOFF_MIN = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_BACKOFF_MAX = 3'd4;

    // register reset values
    localparam logic [CFG_BITS-1:0] RST_HB_INTERVAL = 31'd5000;
    localparam logic [CFG_BITS-1:0] RST_IDLE_TO     = 31'd15000;
    localparam logic [CFG_BITS-1:0] RST_LOGIN_TO    = 31'd5000;
    localparam logic [CFG_BITS-1:0] RST_BACKOFF_MIN = 31'd200;
    localparam logic [CFG_BITS-1:0] RST_BACKOFF_MAX = 31'd30000;

    localparam logic [CFG_BITS-1:0] CFG_ALL_ONES = {CFG_BITS{1'b1}};
    localparam logic [ATT_BITS-1:0] ATT_MAX      = {ATT_BITS{1'b1}};

    typedef struct packed {
        logic [CFG_BITS-1:0] hb_interval;
        logic [CFG_BITS-1:0] idle_to;
        logic [CFG_BITS-1:0] login_to;
        logic [CFG_BITS-1:0] backoff_min;
        logic [CFG_BITS-1:0] backoff_max;
    } t_cfg;

    typedef struct packed {
        logic [MODE_BITS-1:0] link_mode;
        logic [TIME_BITS-1:0] retry_time;
        logic [TIME_BITS-1:0] last_sent;
        logic [TIME_BITS-1:0] last_rcvd;
        logic [TIME_BITS-1:0] login_start;
        logic [CFG_BITS-1:0]  backoff;
        logic [ATT_BITS-1:0]  attempts;
    } t_state;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [TIME_BITS-1:0] now_ms;
        logic                 login_accepted;
        logic                 queue_full;
    } t_item;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [MODE_BITS-1:0] link_state;
        logic                 should_connect;
        logic [CFG_BITS-1:0]  retry_in;
        logic                 send_heartbeat;
        logic                 send_login;
        logic [ATT_BITS-1:0]  attempt_count;
    } t_res;

    // True when the wrapped time since stamp has reached thr; now behind stamp counts as zero.
    function automatic logic f_elapsed_ge(
        input logic [TIME_BITS-1:0] now,
        input logic [TIME_BITS-1:0] stamp,
        input logic [CFG_BITS-1:0]  thr
    );
        logic [TIME_BITS-1:0] diff;
        logic [TIME_BITS-1:0] elapsed;
        diff    = now - stamp;
        elapsed = diff[TIME_BITS-1] ? '0 : diff;
        return elapsed >= {{(TIME_BITS-CFG_BITS){1'b0}}, thr};
    endfunction

endpackage

// File: rtl/lkrc_cfg.sv
// Configuration register file: timeouts, heartbeat interval and backoff bounds.
// Depends on lkrc_pkg.
module lkrc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lkrc_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  logic [lkrc_pkg::CFG_BITS-1:0] i_cfg_data,
    output lkrc_pkg::t_cfg                o_cfg
);
    import lkrc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hb_interval <= RST_HB_INTERVAL;
            r_cfg.idle_to     <= RST_IDLE_TO;
            r_cfg.login_to    <= RST_LOGIN_TO;
            r_cfg.backoff_min <= RST_BACKOFF_MIN;
            r_cfg.backoff_max <= RST_BACKOFF_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HB_INTERVAL: r_cfg.hb_interval <= i_cfg_data;
                REG_IDLE_TO:     r_cfg.idle_to     <= i_cfg_data;
                REG_LOGIN_TO:    r_cfg.login_to    <= i_cfg_data;
                REG_BACKOFF_MIN: r_cfg.backoff_min <= i_cfg_data;
                REG_BACKOFF_MAX: r_cfg.backoff_max <= i_cfg_data;
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/lkrc_step.sv
// Per-event next-state and result logic of the session liveness controller.
// Depends on lkrc_pkg.
module lkrc_step (
    input  lkrc_pkg::t_state i_state,
    input  lkrc_pkg::t_item  i_item,
    input  lkrc_pkg::t_cfg   i_cfg,
    output lkrc_pkg::t_state o_next,
    output lkrc_pkg::t_res   o_res
);
    import lkrc_pkg::*;

    logic                 idle_hit;
    logic                 login_hit;
    logic                 hb_hit;
    logic                 drop;
    logic [STAT_BITS-1:0] status;
    logic                 hb;
    logic                 lg;
    t_state               mid;
    logic [CFG_BITS:0]    dbl;
    logic [TIME_BITS-1:0] since_retry;
    logic [TIME_BITS-1:0] to_retry;

    assign idle_hit  = f_elapsed_ge(i_item.now_ms, i_state.last_rcvd, i_cfg.idle_to);
    assign login_hit = f_elapsed_ge(i_item.now_ms, i_state.login_start, i_cfg.login_to);
    assign hb_hit    = f_elapsed_ge(i_item.now_ms, i_state.last_sent, i_cfg.hb_interval);

    // event decode
    always_comb begin
        mid    = i_state;
        drop   = 1'b0;
        status = ST_OK;
        hb     = 1'b0;
        lg     = 1'b0;
        unique case (i_item.kind)
            KIND_TICK: begin
                if (i_state.link_mode != MODE_DOWN) begin
                    priority if (idle_hit) begin
                        drop   = 1'b1;
                        status = ST_IO;
                    end else if (i_state.link_mode == MODE_LOGIN) begin
                        if (login_hit) begin
                            drop   = 1'b1;
                            status = ST_NOLOGIN;
                        end
                    end else if (hb_hit) begin
                        if (i_item.queue_full) begin
                            drop   = 1'b1;
                            status = ST_QFULL;
                        end else begin
                            hb            = 1'b1;
                            mid.last_sent = i_item.now_ms;
                        end
                    end
                end
            end
            KIND_CONNECT: begin
                if (i_state.link_mode != MODE_DOWN) begin
                    status = ST_DUP;
                end else begin
                    mid.link_mode   = MODE_LOGIN;
                    mid.login_start = i_item.now_ms;
                    mid.last_rcvd   = i_item.now_ms;
                    mid.last_sent   = i_item.now_ms;
                    if (i_item.queue_full) begin
                        status = ST_QFULL;
                    end else begin
                        lg = 1'b1;
                    end
                end
            end
            KIND_LOGIN: begin
                if (i_state.link_mode == MODE_DOWN) begin
                    status = ST_NOLOGIN;
                end else begin
                    mid.last_rcvd = i_item.now_ms;
                    if (i_state.link_mode == MODE_LOGIN) begin
                        if (!i_item.login_accepted) begin
                            drop   = 1'b1;
                            status = ST_NOLOGIN;
                        end else begin
                            mid.link_mode = MODE_READY;
                            mid.attempts  = '0;
                            mid.backoff   = i_cfg.backoff_min;
                        end
                    end
                end
            end
            KIND_FRAME: begin
                if (i_state.link_mode == MODE_DOWN) begin
                    status = ST_NOLOGIN;
                end else begin
                    mid.last_rcvd = i_item.now_ms;
                end
            end
            KIND_SEND: begin
                if (i_state.link_mode != MODE_READY) begin
                    status = ST_NOLOGIN;
                end else if (i_item.queue_full) begin
                    status = ST_QFULL;
                end else begin
                    mid.last_sent = i_item.now_ms;
                end
            end
            KIND_LOST: begin
                drop   = (i_state.link_mode != MODE_DOWN);
                status = ST_IO;
            end
            default: begin
                // unused kinds leave everything as is
            end
        endcase
    end

    // drop: schedule the retry, count the attempt, double the backoff up to backoff_max
    assign dbl = {i_state.backoff, 1'b0};

    always_comb begin
        o_next = mid;
        if (drop) begin
            o_next.link_mode  = MODE_DOWN;
            o_next.retry_time = i_item.now_ms
                              + {{(TIME_BITS-CFG_BITS){1'b0}}, i_state.backoff};
            if (i_state.attempts != ATT_MAX) begin
                o_next.attempts = i_state.attempts + 1'b1;
            end
            if (i_state.backoff < i_cfg.backoff_max) begin
                if (i_state.backoff == '0 || dbl > {1'b0, i_cfg.backoff_max}) begin
                    o_next.backoff = i_cfg.backoff_max;
                end else begin
                    o_next.backoff = dbl[CFG_BITS-1:0];
                end
            end
        end
    end

    assign since_retry = i_item.now_ms - i_state.retry_time;
    assign to_retry    = i_state.retry_time - i_item.now_ms;

    // retry report; after a drop the distance to the new retry time is the old backoff
    always_comb begin
        o_res.status         = status;
        o_res.link_state     = o_next.link_mode;
        o_res.send_heartbeat = hb;
        o_res.send_login     = lg;
        o_res.attempt_count  = o_next.attempts;
        o_res.should_connect = 1'b0;
        o_res.retry_in       = '0;
        if (o_next.link_mode == MODE_DOWN) begin
            if (drop) begin
                o_res.should_connect = (i_state.backoff == '0);
                o_res.retry_in       = i_state.backoff;
            end else if (!since_retry[TIME_BITS-1]) begin
                o_res.should_connect = 1'b1;
            end else if (|to_retry[TIME_BITS-1:CFG_BITS]) begin
                o_res.retry_in = CFG_ALL_ONES;
            end else begin
                o_res.retry_in = to_retry[CFG_BITS-1:0];
            end
        end
    end

endmodule

// File: rtl/link_keepalive_reconnect_controller.sv
// Top level of the link keepalive reconnect controller: event register, state, result register.
// Depends on lkrc_pkg, lkrc_cfg and lkrc_step.
//
//   channel   handshake            payload
//   event     i_valid / o_ready    i_kind, i_now_ms, i_login_accepted, i_queue_full
//   result    o_valid / i_ready    o_status, o_link_state, o_should_connect, o_retry_in,
//                                  o_send_heartbeat, o_send_login, o_attempt_count
//   config    i_cfg_we             i_cfg_idx, i_cfg_data (write only, no wait)
//
// One event per cycle sustained while the result side is ready; each beat passes the event
// register, then the result register. Link state is updated in the same cycle the
// event moves into the result register, so consecutive events see each other's effect.
// o_ready stays high while the event register is empty or moving on; a stalled result
// holds both registers. Reset is synchronous and clears state, config and valid flags.
module link_keepalive_reconnect_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lkrc_pkg::KIND_BITS-1:0] i_kind,
    input  logic [lkrc_pkg::TIME_BITS-1:0] i_now_ms,
    input  logic                           i_login_accepted,
    input  logic                           i_queue_full,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lkrc_pkg::STAT_BITS-1:0] o_status,
    output logic [lkrc_pkg::MODE_BITS-1:0] o_link_state,
    output logic                           o_should_connect,
    output logic [lkrc_pkg::CFG_BITS-1:0]  o_retry_in,
    output logic                           o_send_heartbeat,
    output logic                           o_send_login,
    output logic [lkrc_pkg::ATT_BITS-1:0]  o_attempt_count,
    input  logic                           i_cfg_we,
    input  logic [lkrc_pkg::IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lkrc_pkg::CFG_BITS-1:0]  i_cfg_data
);
    import lkrc_pkg::*;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    t_item  r_in;
    logic   r_in_vld;
    t_res   r_out;
    t_res   n_out;
    logic   r_out_vld;
    logic   adv;

    lkrc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lkrc_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_next  (n_state),
        .o_res   (n_out)
    );

    // advance the event register into the result register
    assign adv     = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.kind           <= i_kind;
            r_in.now_ms         <= i_now_ms;
            r_in.login_accepted <= i_login_accepted;
            r_in.queue_full     <= i_queue_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.link_mode   <= MODE_DOWN;
            r_state.retry_time  <= '0;
            r_state.last_sent   <= '0;
            r_state.last_rcvd   <= '0;
            r_state.login_start <= '0;
            r_state.backoff     <= RST_BACKOFF_MIN;
            r_state.attempts    <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_status         = r_out.status;
    assign o_link_state     = r_out.link_state;
    assign o_should_connect = r_out.should_connect;
    assign o_retry_in       = r_out.retry_in;
    assign o_send_heartbeat = r_out.send_heartbeat;
    assign o_send_login     = r_out.send_login;
    assign o_attempt_count  = r_out.attempt_count;

    // a waiting event holds while the result side is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld && $stable(r_in))
        else $error("event register changed while stalled");

    // the reported link state is the state register after the beat
    a_mode_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_link_state == r_state.link_mode && o_attempt_count == r_state.attempts)
        else $error("result disagrees with state register");

    // retry report only while down, and never both due and pending
    a_retry_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_should_connect || o_retry_in != '0) |->
            o_link_state == MODE_DOWN && !(o_should_connect && o_retry_in != '0))
        else $error("retry report outside down state");

    // a heartbeat goes out only from ready with ok status
    a_hb_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_heartbeat |-> o_link_state == MODE_READY && o_status == ST_OK)
        else $error("heartbeat outside ready state");

    // a login request goes out only on entering logging in
    a_login_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_login |-> o_link_state == MODE_LOGIN && o_status == ST_OK
            && !o_send_heartbeat)
        else $error("login request outside logging in");

endmodule

// File: verif/link_keepalive_reconnect_controller_test.sv
// Self-checking testbench for link_keepalive_reconnect_controller: a directed table, then
// random event streams under several register settings and connect / loss pairs, checked
// by a session predictor or typed rows. Depends on lkrc_pkg and the rtl of the block.
module link_keepalive_reconnect_controller_test;
    import lkrc_pkg::*;

    localparam int DIR_ROWS         = 26;
    localparam int PHASES           = 7;
    localparam int EVENTS_PER_PHASE = 290;
    localparam int HOLD_AT          = 50;
    localparam int HOLD_CYCLES      = 60;
    localparam int SETTLE_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MAX_REPORTS      = 40;
    localparam int LOSS_PAIRS       = 8;

    localparam logic [KIND_BITS-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [TIME_BITS-1:0] NEAR_WRAP    = 48'hFFFF_FFFF_0000;
    localparam logic [TIME_BITS-1:0] TIME_TOP     = 48'hFFFF_FFFF_FFFF;
    localparam logic [TIME_BITS-1:0] WRAP_LOGIN   = 48'hFFFF_FFFF_FFF0;

    localparam logic [IDX_BITS-1:0] REG_ORDER [5] = '{
        REG_HB_INTERVAL, REG_IDLE_TO, REG_LOGIN_TO, REG_BACKOFF_MIN, REG_BACKOFF_MAX
    };

    // hb_interval, idle_to, login_to, backoff_min, backoff_max
    localparam t_cfg PHASE_CFG [PHASES] = '{
        '{RST_HB_INTERVAL, RST_IDLE_TO, RST_LOGIN_TO, RST_BACKOFF_MIN, RST_BACKOFF_MAX},
        '{31'd1, 31'd1, 31'd1, 31'd1, 31'd1},
        '{CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES},
        '{31'd50, 31'd200, 31'd80, 31'd3, 31'd1000},
        '{31'd20, 31'd70, 31'd30, 31'd500, 31'd100},
        '{31'd0, 31'd40, 31'd0, 31'd0, CFG_ALL_ONES},
        '{31'd1000, 31'd3000, 31'd1500, 31'd100, CFG_ALL_ONES}
    };

    typedef struct packed {
        t_item ev;
        logic  typed;
        t_res  want;
    } t_row;

    localparam t_res NO_RES = '0;

    // Rows with typed = 1 carry their result; the others are left to the predictor.
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{'{KIND_TICK, 48'd0, 1'b0, 1'b0}, 1'b1,
          '{ST_OK, MODE_DOWN, 1'b1, 31'd0, 1'b0, 1'b0, 16'd0}},
        '{'{KIND_FRAME, 48'd0, 1'b0, 1'b0}, 1'b1,
          '{ST_NOLOGIN, MODE_DOWN, 1'b1, 31'd0, 1'b0, 1'b0, 16'd0}},
        '{'{KIND_LOGIN, 48'd0, 1'b1, 1'b0}, 1'b1,
          '{ST_NOLOGIN, MODE_DOWN, 1'b1, 31'd0, 1'b0, 1'b0, 16'd0}},
        '{'{KIND_LOST, 48'd0, 1'b0, 1'b0}, 1'b1,
          '{ST_IO, MODE_DOWN, 1'b1, 31'd0, 1'b0, 1'b0, 16'd0}},
        '{'{KIND_SPARE_6, 48'd0, 1'b1, 1'b1}, 1'b1,
          '{ST_OK, MODE_DOWN, 1'b1, 31'd0, 1'b0, 1'b0, 16'd0}},
        '{'{KIND_CONNECT, 48'd100, 1'b0, 1'b0}, 1'b1,
          '{ST_OK, MODE_LOGIN, 1'b0, 31'd0, 1'b0, 1'b1, 16'd0}},
        '{'{KIND_CONNECT, 48'd100, 1'b0, 1'b0}, 1'b1,
          '{ST_DUP, MODE_LOGIN, 1'b0, 31'd0, 1'b0, 1'b0, 16'd0}},
        '{'{KIND_SEND, 48'd100, 1'b0, 1'b0}, 1'b1,
          '{ST_NOLOGIN, MODE_LOGIN, 1'b0, 31'd0, 1'b0, 1'b0, 16'd0}},
        '{'{KIND_TICK, 48'd5099, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_TICK, 48'd5100, 1'b0, 1'b0}, 1'b1,
          '{ST_NOLOGIN, MODE_DOWN, 1'b0, 31'd200, 1'b0, 1'b0, 16'd1}},
        '{'{KIND_CONNECT, 48'd5300, 1'b0, 1'b1}, 1'b1,
          '{ST_QFULL, MODE_LOGIN, 1'b0, 31'd0, 1'b0, 1'b0, 16'd1}},
        '{'{KIND_LOGIN, 48'd5400, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_CONNECT, 48'd5800, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_LOGIN, 48'd5900, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_LOGIN, 48'd6000, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_SEND, 48'd6000, 1'b0, 1'b1}, 1'b1,
          '{ST_QFULL, MODE_READY, 1'b0, 31'd0, 1'b0, 1'b0, 16'd0}},
        '{'{KIND_SEND, 48'd6100, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_TICK, 48'd11100, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_TICK, 48'd16100, 1'b0, 1'b1}, 1'b0, NO_RES},
        '{'{KIND_CONNECT, WRAP_LOGIN, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_LOGIN, 48'h10, 1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_TICK, 48'h5, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_LOST, 48'h20, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_LOST, 48'h20, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_CONNECT, TIME_TOP, 1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{KIND_TICK, 48'd14999, 1'b0, 1'b0}, 1'b0, NO_RES}
    };

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [KIND_BITS-1:0] i_kind;
    logic [TIME_BITS-1:0] i_now_ms;
    logic                 i_login_accepted;
    logic                 i_queue_full;
    logic                 o_valid;
    logic                 i_ready;
    logic [STAT_BITS-1:0] o_status;
    logic [MODE_BITS-1:0] o_link_state;
    logic                 o_should_connect;
    logic [CFG_BITS-1:0]  o_retry_in;
    logic                 o_send_heartbeat;
    logic                 o_send_login;
    logic [ATT_BITS-1:0]  o_attempt_count;
    logic                 i_cfg_we;
    logic [IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_BITS-1:0]  i_cfg_data;

    link_keepalive_reconnect_controller u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_cfg                 regs;
    t_state               session;
    t_res                 pending_results [$];
    logic [TIME_BITS-1:0] clock_ms;
    int unsigned          events_in;
    int unsigned          results_seen;
    int unsigned          mismatches;
    int unsigned          burst_left;
    int unsigned          holds_done;
    bit                   hold_request;

    // ---------------------------------------------------------------- predictor

    // Wrapped time from stamp to now; now behind the stamp counts as nothing elapsed.
    function automatic logic [TIME_BITS-1:0] since(input logic [TIME_BITS-1:0] now_v,
                                                   input logic [TIME_BITS-1:0] stamp);
        logic [TIME_BITS-1:0] d;
        d = now_v - stamp;
        return d[TIME_BITS-1] ? '0 : d;
    endfunction

    function automatic void take_link_down(input logic [TIME_BITS-1:0] now_v);
        logic [CFG_BITS:0] doubled;
        session.link_mode  = MODE_DOWN;
        session.retry_time = now_v + TIME_BITS'(session.backoff);
        if (session.attempts != ATT_MAX) begin
            session.attempts = session.attempts + 1'b1;
        end
        if (session.backoff < regs.backoff_max) begin
            doubled = {session.backoff, 1'b0};
            // zero backoff cannot grow by doubling: jump to the ceiling
            if (doubled <= {1'b0, session.backoff} || doubled > {1'b0, regs.backoff_max}) begin
                doubled = {1'b0, regs.backoff_max};
            end
            session.backoff = doubled[CFG_BITS-1:0];
        end
    endfunction

    function automatic t_res step_session(input t_item ev);
        t_res                 r;
        logic [TIME_BITS-1:0] gap;
        r = '0;
        r.status = ST_OK;
        case (ev.kind)
            KIND_TICK: begin
                if (session.link_mode != MODE_DOWN) begin
                    if (since(ev.now_ms, session.last_rcvd) >= TIME_BITS'(regs.idle_to)) begin
                        take_link_down(ev.now_ms);
                        r.status = ST_IO;
                    end else if (session.link_mode == MODE_LOGIN) begin
                        if (since(ev.now_ms, session.login_start)
                                >= TIME_BITS'(regs.login_to)) begin
                            take_link_down(ev.now_ms);
                            r.status = ST_NOLOGIN;
                        end
                    end else if (since(ev.now_ms, session.last_sent)
                                 >= TIME_BITS'(regs.hb_interval)) begin
                        if (ev.queue_full) begin
                            take_link_down(ev.now_ms);
                            r.status = ST_QFULL;
                        end else begin
                            r.send_heartbeat  = 1'b1;
                            session.last_sent = ev.now_ms;
                        end
                    end
                end
            end
            KIND_CONNECT: begin
                if (session.link_mode != MODE_DOWN) begin
                    r.status = ST_DUP;
                end else begin
                    session.link_mode   = MODE_LOGIN;
                    session.login_start = ev.now_ms;
                    session.last_rcvd   = ev.now_ms;
                    session.last_sent   = ev.now_ms;
                    if (ev.queue_full) begin
                        r.status = ST_QFULL;
                    end else begin
                        r.send_login = 1'b1;
                    end
                end
            end
            KIND_LOGIN: begin
                if (session.link_mode == MODE_DOWN) begin
                    r.status = ST_NOLOGIN;
                end else begin
                    session.last_rcvd = ev.now_ms;
                    if (session.link_mode == MODE_LOGIN) begin
                        if (!ev.login_accepted) begin
                            take_link_down(ev.now_ms);
                            r.status = ST_NOLOGIN;
                        end else begin
                            session.link_mode = MODE_READY;
                            session.attempts  = '0;
                            session.backoff   = regs.backoff_min;
                        end
                    end
                end
            end
            KIND_FRAME: begin
                if (session.link_mode == MODE_DOWN) begin
                    r.status = ST_NOLOGIN;
                end else begin
                    session.last_rcvd = ev.now_ms;
                end
            end
            KIND_SEND: begin
                if (session.link_mode != MODE_READY) begin
                    r.status = ST_NOLOGIN;
                end else if (ev.queue_full) begin
                    r.status = ST_QFULL;
                end else begin
                    session.last_sent = ev.now_ms;
                end
            end
            KIND_LOST: begin
                if (session.link_mode != MODE_DOWN) begin
                    take_link_down(ev.now_ms);
                end
                r.status = ST_IO;
            end
            default: ;
        endcase
        if (session.link_mode == MODE_DOWN) begin
            gap = ev.now_ms - session.retry_time;
            if (!gap[TIME_BITS-1]) begin
                r.should_connect = 1'b1;
            end else begin
                gap = session.retry_time - ev.now_ms;
                r.retry_in = (gap > TIME_BITS'(CFG_ALL_ONES)) ? CFG_ALL_ONES
                                                              : gap[CFG_BITS-1:0];
            end
        end
        r.link_state    = session.link_mode;
        r.attempt_count = session.attempts;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [TIME_BITS-1:0] advance_clock();
        logic [CFG_BITS-1:0] span;
        int unsigned         pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0:       span = regs.hb_interval;
            1:       span = regs.idle_to;
            2:       span = regs.login_to;
            3:       span = regs.backoff_max;
            default: span = session.backoff;
        endcase
        if (pick < 40) begin
            clock_ms += TIME_BITS'($urandom_range(0, 60));
        end else if (pick < 65) begin
            clock_ms += TIME_BITS'($urandom_range(0, span));
        end else if (pick < 85) begin
            // land on a deadline or one ms short of it
            case ($urandom_range(0, 3))
                0:       clock_ms = session.last_rcvd + TIME_BITS'(regs.idle_to);
                1:       clock_ms = session.last_sent + TIME_BITS'(regs.hb_interval);
                2:       clock_ms = session.login_start + TIME_BITS'(regs.login_to);
                default: clock_ms = session.retry_time;
            endcase
            clock_ms -= TIME_BITS'($urandom_range(0, 1));
        end else if (pick < 93) begin
            clock_ms -= TIME_BITS'($urandom_range(1, 100));
        end else if (pick < 98) begin
            clock_ms = TIME_BITS'({$urandom, $urandom});
        end
        return clock_ms;
    endfunction

    // Mostly the kinds that move the session forward from its current mode.
    function automatic t_item random_event();
        t_item       ev;
        int unsigned roll;
        ev.now_ms         = advance_clock();
        ev.login_accepted = ($urandom_range(0, 4) != 0);
        ev.queue_full     = ($urandom_range(0, 6) == 0);
        roll              = $urandom_range(0, 99);
        if (roll >= 75) begin
            ev.kind = KIND_BITS'($urandom);
        end else begin
            case (session.link_mode)
                MODE_DOWN:  ev.kind = (roll < 50) ? KIND_CONNECT : KIND_TICK;
                MODE_LOGIN: ev.kind = (roll < 35) ? KIND_LOGIN
                                    : (roll < 60) ? KIND_TICK : KIND_FRAME;
                default:    ev.kind = (roll < 25) ? KIND_TICK
                                    : (roll < 45) ? KIND_SEND
                                    : (roll < 62) ? KIND_FRAME
                                    : (roll < 68) ? KIND_LOGIN : KIND_LOST;
            endcase
        end
        return ev;
    endfunction

    task automatic send_event(input t_item ev, input logic typed, input t_res want);
        t_res predicted;
        i_valid          <= 1'b1;
        i_kind           <= ev.kind;
        i_now_ms         <= ev.now_ms;
        i_login_accepted <= ev.login_accepted;
        i_queue_full     <= ev.queue_full;
        do @(posedge i_clk); while (!o_ready);
        events_in++;
        predicted = step_session(ev);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Bursts of random length, separated by random gaps.
    task automatic pace();
        int unsigned idle;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle != 0) begin
                i_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input t_cfg c);
        logic [CFG_BITS-1:0] vals [5];
        vals = '{c.hb_interval, c.idle_to, c.login_to, c.backoff_min, c.backoff_max};
        i_cfg_we <= 1'b1;
        for (int r = 0; r < 5; r++) begin
            i_cfg_idx  <= REG_ORDER[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        regs = c;
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string what, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: result %0d %s expected %0d, got %0d",
                         $time, results_seen, what, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected, status %0d",
                         $time, o_status);
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("link_state", want.link_state, o_link_state);
                check_field("should_connect", want.should_connect, o_should_connect);
                check_field("retry_in", want.retry_in, o_retry_in);
                check_field("send_heartbeat", want.send_heartbeat, o_send_heartbeat);
                check_field("send_login", want.send_login, o_send_login);
                check_field("attempt_count", want.attempt_count, o_attempt_count);
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial begin
        t_rx_style   rx_style;
        int unsigned style_left;
        int unsigned rx_cycle;
        i_ready    <= 1'b0;
        rx_style   = RX_OPEN;
        style_left = 0;
        rx_cycle   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                // hold off long enough for the block to fill and stall its input
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                holds_done++;
            end
            if (style_left == 0) begin
                rx_style   = t_rx_style'($urandom_range(0, 3));
                style_left = $urandom_range(8, 80);
            end
            style_left--;
            rx_cycle++;
            case (rx_style)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default:   i_ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- watchdog

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- main

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_kind           <= KIND_TICK;
        i_now_ms         <= '0;
        i_login_accepted <= 1'b0;
        i_queue_full     <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= REG_HB_INTERVAL;
        i_cfg_data       <= '0;
        regs = '{RST_HB_INTERVAL, RST_IDLE_TO, RST_LOGIN_TO, RST_BACKOFF_MIN, RST_BACKOFF_MAX};
        session = '{MODE_DOWN, '0, '0, '0, '0, RST_BACKOFF_MIN, '0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_ROWS; n++) begin
            send_event(DIRECTED[n].ev, DIRECTED[n].typed, DIRECTED[n].want);
            pace();
        end
        clock_ms = DIRECTED[DIR_ROWS-1].ev.now_ms;
        drain();

        for (int p = 0; p < PHASES; p++) begin
            load_settings(PHASE_CFG[p]);
            if (p == PHASES - 1) begin
                clock_ms = NEAR_WRAP;
            end
            for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
                if (n == HOLD_AT) begin
                    hold_request = 1'b1;
                end
                send_event(random_event(), 1'b0, NO_RES);
                pace();
            end
            drain();
        end

        // back-to-back connect / loss pairs: attempts climb and the backoff doubles up to backoff_max
        for (int n = 0; n < 2 * LOSS_PAIRS; n++) begin
            t_item ev;
            clock_ms++;
            ev.now_ms         = clock_ms;
            ev.login_accepted = 1'b0;
            ev.queue_full     = 1'b0;
            ev.kind = (session.link_mode == MODE_DOWN) ? KIND_CONNECT : KIND_LOST;
            send_event(ev, 1'b0, NO_RES);
        end
        drain();

        $display("run covered %0d events: directed table, %0d register settings, %0d long stalls",
                 events_in, PHASES, holds_done);
        $display("%0d results checked, closing connect / loss run back to back, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lkrc_pkg.sv
rtl/lkrc_cfg.sv
rtl/lkrc_step.sv
rtl/link_keepalive_reconnect_controller.sv
verif/link_keepalive_reconnect_controller_test.sv
